>>> sv/lsoc_pkg.sv
// Shared types and constants for the lidar scan obstacle classifier.
// No dependencies.
package lsoc_pkg;

  localparam int MAX_SAMPLES = 4096;
  localparam int IDX_W       = 12;
  localparam int RANGE_W     = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [IDX_W-1:0] LAST_INDEX = IDX_W'(MAX_SAMPLES - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AVOID_DIST    = 3'd0,
    REG_CRITICAL_DIST = 3'd1,
    REG_RANGE_MIN     = 3'd2,
    REG_RANGE_MAX     = 3'd3,
    REG_AHEAD_CENTER  = 3'd4,
    REG_AHEAD_HALF    = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [RANGE_W-1:0] range_mm;
    logic               scan_end;
  } in_item_t;

  typedef struct packed {
    logic               all_clear;
    logic               ahead_clear;
    logic [RANGE_W-1:0] danger_mm;
    logic [IDX_W-1:0]   first_obstacle_index;
    logic [IDX_W-1:0]   last_obstacle_index;
  } out_item_t;

  typedef struct packed {
    logic [RANGE_W-1:0] avoid_dist_mm;
    logic [RANGE_W-1:0] critical_dist_mm;
    logic [RANGE_W-1:0] range_min_mm;
    logic [RANGE_W-1:0] range_max_mm;
    logic [IDX_W-1:0]   ahead_center_index;
    logic [IDX_W-1:0]   ahead_half_width;
  } cfg_t;

endpackage

>>> sv/lsoc_cfg.sv
// Configuration register file for the classifier.
// Depends on lsoc_pkg.
module lsoc_cfg import lsoc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.avoid_dist_mm      <= RANGE_W'(2000);
      cfg.critical_dist_mm   <= RANGE_W'(1000);
      cfg.range_min_mm       <= '0;
      cfg.range_max_mm       <= '1;
      cfg.ahead_center_index <= '0;
      cfg.ahead_half_width   <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_AVOID_DIST:    cfg.avoid_dist_mm      <= wr_data[RANGE_W-1:0];
        REG_CRITICAL_DIST: cfg.critical_dist_mm   <= wr_data[RANGE_W-1:0];
        REG_RANGE_MIN:     cfg.range_min_mm       <= wr_data[RANGE_W-1:0];
        REG_RANGE_MAX:     cfg.range_max_mm       <= wr_data[RANGE_W-1:0];
        REG_AHEAD_CENTER:  cfg.ahead_center_index <= wr_data[IDX_W-1:0];
        REG_AHEAD_HALF:    cfg.ahead_half_width   <= wr_data[IDX_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

>>> sv/lsoc_accum.sv
// Per-scan running summary: sample classification, state update and result build.
// Depends on lsoc_pkg.
module lsoc_accum import lsoc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      take,
  input  in_item_t  item,
  output logic      emit,
  output out_item_t result
);

  logic [IDX_W-1:0]   sample_index, sample_index_next;
  logic               seen_obstacle, seen_obstacle_next;
  logic               seen_ahead_obstacle, seen_ahead_obstacle_next;
  logic               seen_danger, seen_danger_next;
  logic [RANGE_W-1:0] danger_value, danger_value_next;
  logic [IDX_W-1:0]   first_index, first_index_next;
  logic [IDX_W-1:0]   last_index, last_index_next;

  logic               valid_smp, is_obst, is_danger, in_window;
  logic [IDX_W:0]     lo_sum, hi_sum;

  always_comb begin
    valid_smp = (cfg.range_min_mm < item.range_mm) && (item.range_mm < cfg.range_max_mm);
    is_obst   = valid_smp && (item.range_mm < cfg.avoid_dist_mm);
    is_danger = valid_smp && (item.range_mm < cfg.critical_dist_mm);
    // center - half <= idx <= center + half, without underflow
    lo_sum    = {1'b0, sample_index} + {1'b0, cfg.ahead_half_width};
    hi_sum    = {1'b0, cfg.ahead_center_index} + {1'b0, cfg.ahead_half_width};
    in_window = (lo_sum >= {1'b0, cfg.ahead_center_index}) &&
                ({1'b0, sample_index} <= hi_sum);

    seen_obstacle_next       = seen_obstacle || is_obst;
    seen_ahead_obstacle_next = seen_ahead_obstacle || (is_obst && in_window);
    first_index_next         = (is_obst && !seen_obstacle) ? sample_index : first_index;
    last_index_next          = is_obst ? sample_index : last_index;
    seen_danger_next         = seen_danger || is_danger;
    danger_value_next        = (is_danger && !seen_danger) ?
                               cfg.critical_dist_mm - item.range_mm : danger_value;
    sample_index_next        = (sample_index < LAST_INDEX) ?
                               sample_index + IDX_W'(1) : sample_index;

    emit                         = take && item.scan_end;
    result.all_clear             = !seen_obstacle_next;
    result.ahead_clear           = !seen_ahead_obstacle_next;
    result.danger_mm             = seen_danger_next ? danger_value_next : '0;
    result.first_obstacle_index  = seen_obstacle_next ? first_index_next : '0;
    result.last_obstacle_index   = seen_obstacle_next ? last_index_next : sample_index;
  end

  always_ff @(posedge clk) begin
    if (rst || emit) begin
      sample_index        <= '0;
      seen_obstacle       <= 1'b0;
      seen_ahead_obstacle <= 1'b0;
      seen_danger         <= 1'b0;
      danger_value        <= '0;
      first_index         <= '0;
      last_index          <= '0;
    end else if (take) begin
      sample_index        <= sample_index_next;
      seen_obstacle       <= seen_obstacle_next;
      seen_ahead_obstacle <= seen_ahead_obstacle_next;
      seen_danger         <= seen_danger_next;
      danger_value        <= danger_value_next;
      first_index         <= first_index_next;
      last_index          <= last_index_next;
    end
  end

endmodule

>>> sv/lidar_scan_obstacle_classifier.sv
// Top level of the lidar scan obstacle classifier: config, accumulator, result register.
// Depends on lsoc_pkg, lsoc_cfg and lsoc_accum.
//
// Takes one range sample per clock cycle while in_ready is high; a sample is
// folded into the scan summary in the cycle it is transferred. The sample flagged
// scan_end yields one summary result, presented from the output register in the
// next cycle, and the summary restarts for the next scan. in_ready is low only while a
// result sits in the output register and out_ready is low. Sample indexes
// saturate at 4095. Configuration writes take effect on the next cycle.
module lidar_scan_obstacle_classifier import lsoc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t      cfg;
  logic      take, emit;
  out_item_t result;

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  lsoc_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_wr_en),
    .wr_index (cfg_index),
    .wr_data  (cfg_wdata),
    .cfg      (cfg)
  );

  lsoc_accum u_accum (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .take   (take),
    .item   (in_data),
    .emit   (emit),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data <= result;
    end
  end

  a_end_gives_result: assert property (@(posedge clk) disable iff (rst)
    take && in_data.scan_end |=> out_valid)
    else $error("scan end transfer did not produce a result");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  a_clear_first_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.all_clear |-> out_data.first_obstacle_index == '0)
    else $error("clear scan reports a first obstacle index");

  a_clear_ahead: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.all_clear |-> out_data.ahead_clear)
    else $error("clear scan reports an obstacle ahead");

endmodule

>>> test/lidar_scan_obstacle_classifier_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for lidar_scan_obstacle_classifier: streams scans of range
// samples over valid/ready, predicts each scan summary locally and checks every result.
// Depends on lsoc_pkg and the classifier RTL.
module lidar_scan_obstacle_classifier_test;
  import lsoc_pkg::*;

  localparam int     CLK_HALF      = 10;
  localparam int     RESET_CYCLES  = 9;
  localparam int     SETTLE_CYCLES = 4;
  localparam int     LONG_HOLD     = 300;
  localparam int     MAX_WAIT      = 17;
  localparam longint LIMIT_CYCLES  = 1_000_000;

  // indexes past the register list; writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  typedef enum int {PACE_NONE, PACE_FULL, PACE_SPARSE} pace_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  lidar_scan_obstacle_classifier u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #CLK_HALF clk = ~clk;

  // local copy of the registers and of the running scan summary
  cfg_t               regs_model;
  logic [IDX_W-1:0]   scan_idx;
  logic               obstacle_seen;
  logic               ahead_seen;
  logic               danger_seen;
  logic [RANGE_W-1:0] danger_val;
  logic [IDX_W-1:0]   first_idx;
  logic [IDX_W-1:0]   last_idx;

  in_item_t  sample_q[$];
  out_item_t summary_q[$];
  out_item_t expected_summary;

  pace_t  in_pace       = PACE_FULL;
  pace_t  out_pace      = PACE_FULL;
  int     in_wait       = 0;
  int     out_wait      = 0;
  logic   hold_off      = 1'b0;
  logic   sample_taken  = 1'b0;
  logic   summary_taken = 1'b0;
  int     samples_queued    = 0;
  int     samples_taken     = 0;
  int     summaries_checked = 0;
  int     settings_used     = 0;
  int     errors            = 0;
  longint cycle_count       = 0;

  task automatic clear_scan_model();
    scan_idx      = '0;
    obstacle_seen = 1'b0;
    ahead_seen    = 1'b0;
    danger_seen   = 1'b0;
    danger_val    = '0;
    first_idx     = '0;
    last_idx      = '0;
  endtask

  task automatic fold_sample(in_item_t s);
    logic      in_limits;
    longint    win_lo;
    longint    win_hi;
    out_item_t res;
    in_limits = (regs_model.range_min_mm < s.range_mm) &&
                (s.range_mm < regs_model.range_max_mm);
    win_lo = longint'(regs_model.ahead_center_index) - longint'(regs_model.ahead_half_width);
    win_hi = longint'(regs_model.ahead_center_index) + longint'(regs_model.ahead_half_width);
    if (in_limits && s.range_mm < regs_model.avoid_dist_mm) begin
      if (!obstacle_seen) first_idx = scan_idx;
      last_idx      = scan_idx;
      obstacle_seen = 1'b1;
      if (longint'(scan_idx) >= win_lo && longint'(scan_idx) <= win_hi) ahead_seen = 1'b1;
    end
    if (in_limits && s.range_mm < regs_model.critical_dist_mm && !danger_seen) begin
      danger_seen = 1'b1;
      danger_val  = regs_model.critical_dist_mm - s.range_mm;
    end
    if (!s.scan_end) begin
      if (scan_idx != LAST_INDEX) scan_idx++;
    end else begin
      res.all_clear            = !obstacle_seen;
      res.ahead_clear          = !ahead_seen;
      res.danger_mm            = danger_seen ? danger_val : '0;
      res.first_obstacle_index = obstacle_seen ? first_idx : '0;
      res.last_obstacle_index  = obstacle_seen ? last_idx : scan_idx;
      summary_q.push_back(res);
      clear_scan_model();
    end
  endtask

  function automatic int draw_wait(pace_t p);
    case (p)
      PACE_NONE: return 0;
      PACE_FULL: return $urandom_range(0, MAX_WAIT);
      default:   return ($urandom_range(0, 3) == 0) ? $urandom_range(1, MAX_WAIT) : 0;
    endcase
  endfunction

  // sample transfers feed the predictor
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      fold_sample(in_data);
      samples_taken++;
      sample_taken = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || sample_taken) begin
      sample_taken = 1'b0;
      if (in_wait > 0) begin
        in_valid <= 1'b0;
        in_wait--;
      end else if (sample_q.size() > 0) begin
        in_data  <= sample_q.pop_front();
        in_valid <= 1'b1;
        in_wait  = draw_wait(in_pace);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (summary_taken) begin
        out_wait      = draw_wait(out_pace);
        summary_taken = 1'b0;
      end
      if (hold_off) begin
        out_ready <= 1'b0;
      end else if (out_wait > 0) begin
        out_ready <= 1'b0;
        out_wait--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic check_field(string name, logic [RANGE_W-1:0] want, logic [RANGE_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      summary_taken = 1'b1;
      if (summary_q.size() == 0) begin
        $display("%0t: summary expected none, got %p", $time, out_data);
        errors++;
      end else begin
        expected_summary = summary_q.pop_front();
        check_field("all_clear", RANGE_W'(expected_summary.all_clear),
                    RANGE_W'(out_data.all_clear));
        check_field("ahead_clear", RANGE_W'(expected_summary.ahead_clear),
                    RANGE_W'(out_data.ahead_clear));
        check_field("danger_mm", expected_summary.danger_mm, out_data.danger_mm);
        check_field("first_obstacle_index",
                    RANGE_W'(expected_summary.first_obstacle_index),
                    RANGE_W'(out_data.first_obstacle_index));
        check_field("last_obstacle_index",
                    RANGE_W'(expected_summary.last_obstacle_index),
                    RANGE_W'(out_data.last_obstacle_index));
        summaries_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("lidar_scan_obstacle_classifier_test: done, errors");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_AVOID_DIST:    regs_model.avoid_dist_mm      = val;
      REG_CRITICAL_DIST: regs_model.critical_dist_mm   = val;
      REG_RANGE_MIN:     regs_model.range_min_mm       = val;
      REG_RANGE_MAX:     regs_model.range_max_mm       = val;
      REG_AHEAD_CENTER:  regs_model.ahead_center_index = val[IDX_W-1:0];
      REG_AHEAD_HALF:    regs_model.ahead_half_width   = val[IDX_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // 12-bit registers get random upper write bits, which must be dropped
  task automatic set_regs(logic [RANGE_W-1:0] avoid, logic [RANGE_W-1:0] crit,
                          logic [RANGE_W-1:0] rmin, logic [RANGE_W-1:0] rmax,
                          logic [IDX_W-1:0] center, logic [IDX_W-1:0] half);
    write_reg(REG_AVOID_DIST, avoid);
    write_reg(REG_CRITICAL_DIST, crit);
    write_reg(REG_RANGE_MIN, rmin);
    write_reg(REG_RANGE_MAX, rmax);
    write_reg(REG_AHEAD_CENTER, {4'($urandom_range(0, 15)), center});
    write_reg(REG_AHEAD_HALF, {4'($urandom_range(0, 15)), half});
    settings_used++;
  endtask

  task automatic drain();
    while (samples_taken != samples_queued || summary_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic queue_sample(logic [RANGE_W-1:0] r, logic last);
    in_item_t s;
    s.range_mm = r;
    s.scan_end = last;
    sample_q.push_back(s);
    samples_queued++;
  endtask

  function automatic logic [RANGE_W-1:0] pick_range();
    logic [RANGE_W-1:0] jitter;
    jitter = RANGE_W'($urandom_range(0, 6)) - RANGE_W'(3);
    case ($urandom_range(0, 9))
      0:       return RANGE_W'($urandom);
      1:       return ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
      2:       return regs_model.avoid_dist_mm + jitter;
      3:       return regs_model.critical_dist_mm + jitter;
      4:       return regs_model.range_min_mm + jitter;
      5:       return regs_model.range_max_mm + jitter;
      6, 7:    return RANGE_W'($urandom_range(0, regs_model.avoid_dist_mm));
      default: return RANGE_W'($urandom_range(regs_model.avoid_dist_mm, 16'hFFFF));
    endcase
  endfunction

  task automatic queue_scan(int len);
    for (int i = 0; i < len; i++) queue_sample(pick_range(), i == len - 1);
  endtask

  task automatic random_phase(int n_items, int max_len);
    int left;
    int len;
    left = n_items;
    while (left > 0) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, max_len) : $urandom_range(1, 12);
      queue_scan(len);
      left -= len;
    end
    drain();
  endtask

  initial begin
    logic [RANGE_W-1:0] rmin;
    logic [RANGE_W-1:0] rmax;
    logic [IDX_W-1:0]   center;
    logic [RANGE_W-1:0] r;
    int                 left;

    regs_model.avoid_dist_mm      = 16'd2000;
    regs_model.critical_dist_mm   = 16'd1000;
    regs_model.range_min_mm       = 16'd0;
    regs_model.range_max_mm       = 16'hFFFF;
    regs_model.ahead_center_index = '0;
    regs_model.ahead_half_width   = '0;
    clear_scan_model();
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    // reset settings: range extremes, one-sample scans, thresholds on both sides
    queue_sample(16'hFFFF, 1'b1);
    queue_sample(16'd0, 1'b1);
    queue_sample(16'd1, 1'b1);
    queue_sample(16'd3000, 1'b0);
    queue_sample(16'd1500, 1'b0);
    queue_sample(16'd999, 1'b0);
    queue_sample(16'd1000, 1'b0);
    queue_sample(16'd500, 1'b0);
    queue_sample(16'd65534, 1'b1);
    queue_sample(16'd2000, 1'b0);
    queue_sample(16'd1999, 1'b1);
    drain();

    // equal range limits: nothing valid
    set_regs(16'd2000, 16'd1000, 16'd100, 16'd100, 12'd0, 12'd0);
    queue_sample(16'd100, 1'b0);
    queue_sample(16'd50, 1'b1);
    drain();

    // all thresholds at max, window wider than the index space
    set_regs(16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF, 12'hFFF, 12'hFFF);
    queue_sample(16'd65534, 1'b0);
    queue_sample(16'd1, 1'b1);
    drain();

    // window [2,4]: one obstacle outside, one inside
    set_regs(16'd2000, 16'd1000, 16'd0, 16'hFFFF, 12'd3, 12'd1);
    queue_sample(16'd5000, 1'b0);
    queue_sample(16'd1500, 1'b0);
    queue_sample(16'd5000, 1'b0);
    queue_sample(16'd5000, 1'b0);
    queue_sample(16'd1500, 1'b0);
    queue_sample(16'd5000, 1'b1);
    drain();

    set_regs(16'd2000, 16'd1000, 16'd0, 16'hFFFF, 12'd5, 12'd3);
    random_phase(250, 60);

    in_pace  = PACE_SPARSE;
    out_pace = PACE_NONE;
    set_regs(16'd0, 16'd0, 16'd0, 16'd0, 12'd0, 12'd0);
    random_phase(80, 20);

    in_pace  = PACE_NONE;
    out_pace = PACE_SPARSE;
    set_regs(16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF, 12'hFFF, 12'hFFF);
    random_phase(150, 40);

    for (int k = 0; k < 5; k++) begin
      in_pace  = pace_t'($urandom_range(0, 2));
      out_pace = pace_t'($urandom_range(0, 2));
      if (k == 2) begin
        rmin = RANGE_W'($urandom_range(1000, 16'hFFFF));
        rmax = RANGE_W'($urandom_range(0, 999));
      end else begin
        rmin = RANGE_W'($urandom_range(0, 500));
        rmax = RANGE_W'($urandom_range(20000, 16'hFFFF));
      end
      center = (k == 3) ? IDX_W'(3000) : IDX_W'($urandom_range(0, 40));
      set_regs(RANGE_W'($urandom_range(200, 30000)), RANGE_W'($urandom), rmin, rmax,
               center, IDX_W'($urandom_range(0, 12)));
      write_reg(REG_SPARE_6, CFG_DATA_W'($urandom));
      write_reg(REG_SPARE_7, CFG_DATA_W'($urandom));
      random_phase(220, 80);
    end

    // output held off while short scans keep coming
    in_pace  = PACE_NONE;
    out_pace = PACE_FULL;
    set_regs(16'd2000, 16'd1000, 16'd0, 16'hFFFF, 12'd2, 12'd2);
    fork
      begin
        @(posedge clk);
        hold_off = 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_off = 1'b0;
      end
    join_none
    left = 150;
    while (left > 0) begin
      r = RANGE_W'($urandom_range(1, 3));
      queue_scan(int'(r));
      left -= int'(r);
    end
    drain();

    $display("%0d samples over %0d register settings, %0d scan summaries checked",
             samples_taken, settings_used, summaries_checked);
    $display("incl. inverted limits, window edges, %0d-cycle output stall",
             LONG_HOLD);
    if (errors == 0) begin
      $display("lidar_scan_obstacle_classifier_test: done, clean");
    end else begin
      $display("lidar_scan_obstacle_classifier_test: done, errors");
    end
    $finish;
  end

endmodule
